### design/topocentric_look_angle_window_assert.svh
// Assertion macros shared by the look-angle window RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef TOPOCENTRIC_LOOK_ANGLE_WINDOW_ASSERT_SVH
`define TOPOCENTRIC_LOOK_ANGLE_WINDOW_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TLAW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TLAW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Condition must never be true.
`define TLAW_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

### design/tlaw_pkg.sv
// Shared types, constants and CORDIC helpers for the look-angle window.
// No dependencies; every other design module refers to it by scoped names.
package tlaw_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic signed [35:0] Q30_PI       = 36'sd3373259426;
  localparam logic signed [35:0] Q30_HALF_PI  = 36'sd1686629713;
  localparam logic signed [35:0] Q30_TWO_PI   = 36'sd6746518852;
  localparam logic signed [32:0] Q30_INV_GAIN = 33'sd652032874;
  localparam logic signed [21:0] Q20_GAIN     = 22'sd1726753;
  localparam logic signed [34:0] EARTH_RADIUS = 35'sd6523904;

  typedef enum logic [2:0] {
    CFG_STATION_LONGITUDE = 3'd0,
    CFG_STATION_LATITUDE  = 3'd1,
    CFG_STATION_ALTITUDE  = 3'd2,
    CFG_AZIMUTH_MIN       = 3'd3,
    CFG_AZIMUTH_MAX       = 3'd4,
    CFG_ELEVATION_MIN     = 3'd5,
    CFG_ELEVATION_MAX     = 3'd6
  } cfg_index_t;

  typedef enum logic [2:0] {
    TRIG_LOAD,
    TRIG_REDUCE,
    TRIG_WRAP,
    TRIG_FOLD,
    TRIG_ROT,
    TRIG_IDLE
  } trig_state_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic        visible;
    logic        above_horizon;
    logic [18:0] azimuth;
    logic [16:0] elevation;
  } out_item_t;

  typedef struct packed {
    logic signed [32:0] cos_lon;
    logic signed [32:0] sin_lon;
    logic signed [32:0] cos_lat;
    logic signed [32:0] sin_lat;
  } trig_t;

  typedef struct packed {
    logic signed [57:0] hx;
    logic signed [57:0] hy;
    logic signed [57:0] nzg;
    logic               above;
    logic               zero;
  } q_item_t;

  typedef struct packed {
    logic signed [57:0] x;
    logic signed [57:0] y;
    logic signed [35:0] z;
    logic signed [57:0] aux;
    logic               above;
    logic               zero;
  } bk_stage_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd843314856;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043836;
      5'd3:  v = 30'd133525158;
      5'd4:  v = 30'd67021686;
      5'd5:  v = 30'd33543515;
      5'd6:  v = 30'd16775850;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194282;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;
      5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;
      5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;
      5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;
      5'd19: v = 30'd2047;
      5'd20: v = 30'd1023;
      5'd21: v = 30'd511;
      5'd22: v = 30'd255;
      5'd23: v = 30'd127;
      5'd24: v = 30'd63;
      5'd25: v = 30'd31;
      5'd26: v = 30'd15;
      5'd27: v = 30'd7;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Round a Q30 product sum to the nearest integer, ties toward plus infinity.
  function automatic logic signed [37:0] rnd30(input logic signed [67:0] v);
    logic signed [67:0] s;
    s = (v + 68'sd536870912) >>> 30;
    return s[37:0];
  endfunction

  // One CORDIC vectoring step toward y = 0.
  function automatic bk_stage_t vec_step(input bk_stage_t s, input logic [4:0] i);
    bk_stage_t          o;
    logic signed [57:0] xs;
    logic signed [57:0] ys;
    logic signed [35:0] at;
    o  = s;
    xs = s.x >>> i;
    ys = s.y >>> i;
    at = $signed({6'b0, atan_q30(i)});
    if (s.y > 0) begin
      o.x = s.x + ys;
      o.y = s.y - xs;
      o.z = s.z + at;
    end else begin
      o.x = s.x - ys;
      o.y = s.y + xs;
      o.z = s.z - at;
    end
    return o;
  endfunction

endpackage

### design/topocentric_look_angle_window.sv
// Satellite look-angle window: takes Earth-centered positions and
// returns, per position, azimuth and elevation seen from the station plus
// visibility flags. Sustained rate is one position per clock while in_stall is
// low; the path runs through five rotation stages, the transaction queue, 60
// pipelined CORDIC vectoring stages and the windowing stage. After reset and
// after each write of station longitude or latitude, a shared iterative CORDIC
// recomputes the station sin/cos; in_stall stays high while it runs.
// Depends on tlaw_pkg, tlaw_trig, tlaw_front, tlaw_queue and tlaw_back.
module topocentric_look_angle_window #(
  parameter int ANGLE_FRACTION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tlaw_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tlaw_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [18:0]         cfg_data
);

`include "topocentric_look_angle_window_assert.svh"

  logic signed [18:0] lon_r;
  logic signed [17:0] lat_r;
  logic signed [17:0] alt_r;
  logic [18:0]        az_min_r, az_max_r;
  logic [17:0]        el_min_r, el_max_r;

  logic               cfg_wr, trig_start, trig_busy;
  tlaw_pkg::trig_t    trig;
  logic               front_ready, take, q_push, q_pop, q_full, q_empty;
  tlaw_pkg::q_item_t  q_wdata, q_rdata;

  assign cfg_ready  = 1'b1;
  assign cfg_wr     = cfg_valid && cfg_ready;
  assign trig_start = cfg_wr && ((cfg_index == tlaw_pkg::CFG_STATION_LONGITUDE) ||
                                 (cfg_index == tlaw_pkg::CFG_STATION_LATITUDE));
  assign in_stall   = trig_busy || !front_ready;
  assign take       = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lon_r    <= '0;
      lat_r    <= '0;
      alt_r    <= '0;
      az_min_r <= '0;
      az_max_r <= 19'd411775;
      el_min_r <= 18'd11438;
      el_max_r <= 18'd102944;
    end else if (cfg_wr) begin
      case (cfg_index)
        tlaw_pkg::CFG_STATION_LONGITUDE: lon_r    <= cfg_data;
        tlaw_pkg::CFG_STATION_LATITUDE:  lat_r    <= cfg_data[17:0];
        tlaw_pkg::CFG_STATION_ALTITUDE:  alt_r    <= cfg_data[17:0];
        tlaw_pkg::CFG_AZIMUTH_MIN:       az_min_r <= cfg_data;
        tlaw_pkg::CFG_AZIMUTH_MAX:       az_max_r <= cfg_data;
        tlaw_pkg::CFG_ELEVATION_MIN:     el_min_r <= cfg_data[17:0];
        tlaw_pkg::CFG_ELEVATION_MAX:     el_max_r <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  tlaw_trig #(
    .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)
  ) u_trig (
    .clk   (clk),
    .rst_n (rst_n),
    .start (trig_start),
    .lon   (lon_r),
    .lat   (lat_r),
    .busy  (trig_busy),
    .trig  (trig)
  );

  tlaw_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .in_item     (in_data),
    .trig        (trig),
    .altitude    (alt_r),
    .q_full      (q_full),
    .front_ready (front_ready),
    .push        (q_push),
    .q_item      (q_wdata)
  );

  tlaw_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  tlaw_back #(
    .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_rdata       (q_rdata),
    .pop           (q_pop),
    .azimuth_min   (az_min_r),
    .azimuth_max   (az_max_r),
    .elevation_min (el_min_r),
    .elevation_max (el_max_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

  `TLAW_ASSERT_IMP(a_below_zero, out_valid && !out_data.above_horizon, out_data.azimuth == '0 && out_data.elevation == '0 && !out_data.visible, "below-horizon result carries nonzero angles")
  `TLAW_ASSERT_IMP(a_vis_above, out_valid && out_data.visible, out_data.above_horizon, "visible result not above horizon")
  `TLAW_ASSERT_NXT(a_trig_restart, trig_start, trig_busy, "angle write did not restart sin/cos")
  `TLAW_ASSERT_NEVER(a_queue_ovf, q_push && q_full, "push into full queue")

endmodule

### design/tlaw_trig.sv
// Sequential CORDIC that derives sin/cos of the station longitude and latitude.
// Depends on tlaw_pkg; restarts on reset and on a write of either angle.
module tlaw_trig #(
  parameter int ANGLE_FRACTION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [18:0]  lon,
  input  logic signed [17:0]  lat,
  output logic                busy,
  output tlaw_pkg::trig_t     trig
);

  localparam int SH = 30 - ANGLE_FRACTION_BITS;
  localparam int AW = 19 + SH;
  localparam int MW = (AW > 36) ? AW : 36;
  localparam int RS = (AW > 34) ? AW - 33 : 1;
  localparam int KW = (RS > 1) ? $clog2(RS) : 1;

  tlaw_pkg::trig_state_t state_r, state_nxt;
  logic                  sel_r, sel_nxt;
  logic [KW-1:0]         k_r, k_nxt;
  logic [MW-1:0]         mag_r, mag_nxt;
  logic                  sgn_r, sgn_nxt;
  logic signed [35:0]    r_r, r_nxt;
  logic                  neg_r, neg_nxt;
  logic signed [32:0]    x_r, x_nxt;
  logic signed [32:0]    y_r, y_nxt;
  logic [4:0]            i_r, i_nxt;
  tlaw_pkg::trig_t       trig_r, trig_nxt;

  logic signed [AW-1:0]  ang;
  logic [AW-1:0]         mag_abs;
  logic [MW-1:0]         thr;
  logic signed [35:0]    m36;
  logic signed [35:0]    r0;
  logic signed [32:0]    xs, ys, xr, yr;
  logic signed [35:0]    at, rr;

  assign ang     = sel_r ? {lat[17], lat, {SH{1'b0}}} : {lon, {SH{1'b0}}};
  assign mag_abs = ang[AW-1] ? AW'(-ang) : AW'(ang);
  assign thr     = MW'(tlaw_pkg::Q30_TWO_PI) << k_r;
  assign m36     = $signed(mag_r[35:0]);
  assign r0      = (sgn_r && (m36 != 0)) ? tlaw_pkg::Q30_TWO_PI - m36 : m36;

  // Rotation step on the shared datapath.
  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  assign at = $signed({6'b0, tlaw_pkg::atan_q30(i_r)});
  always_comb begin
    if (r_r >= 0) begin
      xr = x_r - ys;
      yr = y_r + xs;
      rr = r_r - at;
    end else begin
      xr = x_r + ys;
      yr = y_r - xs;
      rr = r_r + at;
    end
  end

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    k_nxt     = k_r;
    mag_nxt   = mag_r;
    sgn_nxt   = sgn_r;
    r_nxt     = r_r;
    neg_nxt   = neg_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    i_nxt     = i_r;
    trig_nxt  = trig_r;
    case (state_r)
      tlaw_pkg::TRIG_LOAD: begin
        mag_nxt   = MW'(mag_abs);
        sgn_nxt   = ang[AW-1];
        k_nxt     = KW'(RS - 1);
        state_nxt = tlaw_pkg::TRIG_REDUCE;
      end
      tlaw_pkg::TRIG_REDUCE: begin
        // Restoring remainder by 2*pi, one shifted modulus per cycle.
        if (mag_r >= thr) begin
          mag_nxt = mag_r - thr;
        end
        if (k_r == '0) begin
          state_nxt = tlaw_pkg::TRIG_WRAP;
        end else begin
          k_nxt = k_r - 1'b1;
        end
      end
      tlaw_pkg::TRIG_WRAP: begin
        r_nxt     = (r0 > tlaw_pkg::Q30_PI) ? r0 - tlaw_pkg::Q30_TWO_PI : r0;
        state_nxt = tlaw_pkg::TRIG_FOLD;
      end
      tlaw_pkg::TRIG_FOLD: begin
        if (r_r > tlaw_pkg::Q30_HALF_PI) begin
          r_nxt   = r_r - tlaw_pkg::Q30_PI;
          neg_nxt = 1'b1;
        end else if (r_r < -tlaw_pkg::Q30_HALF_PI) begin
          r_nxt   = r_r + tlaw_pkg::Q30_PI;
          neg_nxt = 1'b1;
        end else begin
          neg_nxt = 1'b0;
        end
        x_nxt     = tlaw_pkg::Q30_INV_GAIN;
        y_nxt     = '0;
        i_nxt     = '0;
        state_nxt = tlaw_pkg::TRIG_ROT;
      end
      tlaw_pkg::TRIG_ROT: begin
        x_nxt = xr;
        y_nxt = yr;
        r_nxt = rr;
        i_nxt = i_r + 1'b1;
        if (i_r == 5'(tlaw_pkg::CORDIC_STEPS - 1)) begin
          if (sel_r) begin
            trig_nxt.cos_lat = neg_r ? -xr : xr;
            trig_nxt.sin_lat = neg_r ? -yr : yr;
            state_nxt        = tlaw_pkg::TRIG_IDLE;
          end else begin
            trig_nxt.cos_lon = neg_r ? -xr : xr;
            trig_nxt.sin_lon = neg_r ? -yr : yr;
            sel_nxt          = 1'b1;
            state_nxt        = tlaw_pkg::TRIG_LOAD;
          end
        end
      end
      tlaw_pkg::TRIG_IDLE: begin
        state_nxt = tlaw_pkg::TRIG_IDLE;
      end
      default: begin
        state_nxt = tlaw_pkg::TRIG_IDLE;
      end
    endcase
    if (start) begin
      state_nxt = tlaw_pkg::TRIG_LOAD;
      sel_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tlaw_pkg::TRIG_LOAD;
      sel_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    mag_r  <= mag_nxt;
    sgn_r  <= sgn_nxt;
    r_r    <= r_nxt;
    neg_r  <= neg_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    i_r    <= i_nxt;
    trig_r <= trig_nxt;
  end

  assign busy = (state_r != tlaw_pkg::TRIG_IDLE);
  assign trig = trig_r;

endmodule

### design/tlaw_front.sv
// Front pipeline: rotates each position into the station frame and classifies it.
// Depends on tlaw_pkg; feeds tlaw_queue with vectoring operands.
module tlaw_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  tlaw_pkg::in_item_t   in_item,
  input  tlaw_pkg::trig_t      trig,
  input  logic signed [17:0]   altitude,
  input  logic                 q_full,
  output logic                 front_ready,
  output logic                 push,
  output tlaw_pkg::q_item_t    q_item
);

  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  logic signed [64:0] p_xcl_r, p_ysl_r, p_ycl_r, p_xsl_r, p_zcb_r, p_zsb_r;
  logic signed [33:0] u_r, ny2_r;
  logic signed [64:0] zcb2_r, zsb2_r;
  logic signed [66:0] usb_r, ucb_r;
  logic signed [33:0] ny3_r;
  logic signed [64:0] zcb3_r, zsb3_r;
  logic signed [33:0] nx_r, ny4_r;
  logic signed [34:0] nz_r;
  tlaw_pkg::q_item_t  q_r;

  logic signed [64:0] p_xcl, p_ysl, p_ycl, p_xsl, p_zcb, p_zsb;
  logic signed [66:0] usb, ucb;
  logic signed [34:0] nz_sum, hx_abs, hy_s;
  logic signed [56:0] nzg_prod;
  logic               nx_neg;

  assign front_ready = !v5_r || !q_full;
  assign push        = v5_r && !q_full;
  assign q_item      = q_r;

  assign p_xcl = in_item.pos_x * trig.cos_lon;
  assign p_ysl = in_item.pos_y * trig.sin_lon;
  assign p_ycl = in_item.pos_y * trig.cos_lon;
  assign p_xsl = in_item.pos_x * trig.sin_lon;
  assign p_zcb = in_item.pos_z * trig.cos_lat;
  assign p_zsb = in_item.pos_z * trig.sin_lat;

  assign usb = u_r * trig.sin_lat;
  assign ucb = u_r * trig.cos_lat;

  assign nz_sum = 35'(tlaw_pkg::rnd30(68'(ucb_r) + 68'(zsb3_r)));

  // The horizontal vector is mirrored into the right half plane for vectoring.
  assign nx_neg   = nx_r[33];
  assign hx_abs   = nx_neg ? -35'(nx_r) : 35'(nx_r);
  assign hy_s     = nx_neg ? -35'(ny4_r) : 35'(ny4_r);
  assign nzg_prod = nz_r * tlaw_pkg::Q20_GAIN;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (front_ready) begin
      v1_r <= take;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (front_ready) begin
      p_xcl_r <= p_xcl;
      p_ysl_r <= p_ysl;
      p_ycl_r <= p_ycl;
      p_xsl_r <= p_xsl;
      p_zcb_r <= p_zcb;
      p_zsb_r <= p_zsb;

      u_r    <= 34'(tlaw_pkg::rnd30(68'(p_xcl_r) + 68'(p_ysl_r)));
      ny2_r  <= 34'(tlaw_pkg::rnd30(68'(p_ycl_r) - 68'(p_xsl_r)));
      zcb2_r <= p_zcb_r;
      zsb2_r <= p_zsb_r;

      usb_r  <= usb;
      ucb_r  <= ucb;
      ny3_r  <= ny2_r;
      zcb3_r <= zcb2_r;
      zsb3_r <= zsb2_r;

      nx_r  <= 34'(tlaw_pkg::rnd30(68'(zcb3_r) - 68'(usb_r)));
      ny4_r <= ny3_r;
      nz_r  <= nz_sum - (tlaw_pkg::EARTH_RADIUS + 35'(altitude));

      q_r.hx    <= 58'(hx_abs) <<< 20;
      q_r.hy    <= 58'(hy_s) <<< 20;
      q_r.nzg   <= 58'(nzg_prod);
      q_r.above <= (nz_r > 0);
      q_r.zero  <= (nx_r == '0) && (ny4_r == '0);
    end
  end

endmodule

### design/tlaw_queue.sv
// Short register FIFO that decouples the front pipeline from the CORDIC back end.
// Depends on tlaw_pkg for the entry type and depth.
module tlaw_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tlaw_pkg::q_item_t  wdata,
  input  logic               pop,
  output tlaw_pkg::q_item_t  rdata,
  output logic               full,
  output logic               empty
);

  localparam int PW = $clog2(tlaw_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(tlaw_pkg::QUEUE_DEPTH + 1);

  tlaw_pkg::q_item_t mem_r [tlaw_pkg::QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]     count_r;

  assign full  = (count_r == CW'(tlaw_pkg::QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### design/tlaw_back.sv
// Back end: pipelined CORDIC vectoring for azimuth, then elevation, then windowing.
// Depends on tlaw_pkg; pulls entries from tlaw_queue and drives the result register.
module tlaw_back #(
  parameter int ANGLE_FRACTION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  tlaw_pkg::q_item_t   q_rdata,
  output logic                pop,
  input  logic [18:0]         azimuth_min,
  input  logic [18:0]         azimuth_max,
  input  logic [17:0]         elevation_min,
  input  logic [17:0]         elevation_max,
  output logic                out_valid,
  input  logic                out_stall,
  output tlaw_pkg::out_item_t out_data
);

  localparam int NS = 2 * tlaw_pkg::CORDIC_STEPS;
  localparam int SH = 30 - ANGLE_FRACTION_BITS;
  localparam logic signed [35:0] RND     = 36'sd1 <<< (SH - 1);
  localparam logic signed [35:0] EL_HALF = (tlaw_pkg::Q30_HALF_PI + RND) >>> SH;

  tlaw_pkg::bk_stage_t st_r   [0:NS];
  tlaw_pkg::bk_stage_t st_nxt [0:NS-1];
  logic [NS:0]         vld_r;
  logic                out_valid_r;
  tlaw_pkg::out_item_t out_data_r;
  tlaw_pkg::out_item_t res;
  logic                be;

  logic signed [35:0]  az_q, el_q;
  logic [35:0]         az_full, el_full;
  logic                in_win;

  function automatic logic [35:0] from_q30(input logic signed [35:0] a);
    logic signed [35:0] r;
    r = (a + RND) >>> SH;
    return (r < 0) ? '0 : r;
  endfunction

  assign be  = !out_valid_r || !out_stall;
  assign pop = be && !q_empty;

  for (genvar j = 0; j < NS; j++) begin : g_stage
    if (j < tlaw_pkg::CORDIC_STEPS) begin : g_az
      assign st_nxt[j] = tlaw_pkg::vec_step(st_r[j], 5'(j));
    end else if (j == tlaw_pkg::CORDIC_STEPS) begin : g_turn
      // Elevation starts from the azimuth magnitude; the azimuth angle rides along.
      tlaw_pkg::bk_stage_t t;
      assign t.x     = st_r[j].x;
      assign t.y     = st_r[j].aux;
      assign t.z     = '0;
      assign t.aux   = 58'(st_r[j].z);
      assign t.above = st_r[j].above;
      assign t.zero  = st_r[j].zero;
      assign st_nxt[j] = tlaw_pkg::vec_step(t, 5'd0);
    end else begin : g_el
      assign st_nxt[j] = tlaw_pkg::vec_step(st_r[j], 5'(j - tlaw_pkg::CORDIC_STEPS));
    end
  end

  assign az_q    = 36'(st_r[NS].aux[35:0]) + tlaw_pkg::Q30_PI;
  assign el_q    = st_r[NS].z;
  assign az_full = from_q30(az_q);
  assign el_full = from_q30(el_q);
  assign in_win  = (az_full >= 36'(azimuth_min)) && (az_full <= 36'(azimuth_max)) &&
                   (el_full >= 36'(elevation_min)) && (el_full <= 36'(elevation_max));

  always_comb begin
    res = '0;
    if (st_r[NS].above) begin
      res.above_horizon = 1'b1;
      if (st_r[NS].zero) begin
        res.elevation = EL_HALF[16:0];
      end else begin
        res.visible   = in_win;
        res.azimuth   = az_full[18:0];
        res.elevation = el_full[16:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (be) begin
      vld_r       <= {vld_r[NS-1:0], pop};
      out_valid_r <= vld_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      st_r[0].x     <= q_rdata.hx;
      st_r[0].y     <= q_rdata.hy;
      st_r[0].z     <= '0;
      st_r[0].aux   <= q_rdata.nzg;
      st_r[0].above <= q_rdata.above;
      st_r[0].zero  <= q_rdata.zero;
      for (int j = 0; j < NS; j++) begin
        st_r[j+1] <= st_nxt[j];
      end
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
